/* rtl/core/adel_pkg.sv */
package adel_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_POLARITY           = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_LEVEL      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LATCH_ENABLE       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IMMEDIATE_ACTIVATE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SYMMETRIC_WINDOW   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ACTIVATE_WINDOW    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_WINDOW     = 3'd6;

  // Field widths
  localparam int unsigned WinW  = 16;
  localparam int unsigned TimeW = 32;

  // Reset values of the configuration registers
  localparam logic            RST_POLARITY           = 1'b1;
  localparam logic            RST_INITIAL_LEVEL      = 1'b0;
  localparam logic            RST_LATCH_ENABLE       = 1'b0;
  localparam logic            RST_IMMEDIATE_ACTIVATE = 1'b0;
  localparam logic [WinW-1:0] RST_SYMMETRIC_WINDOW   = 16'd20;
  localparam logic [WinW-1:0] RST_ACTIVATE_WINDOW    = 16'd0;
  localparam logic [WinW-1:0] RST_RELEASE_WINDOW     = 16'd0;

  // Debounce state
  typedef struct packed {
    logic             stable_level;
    logic             candidate_level;
    logic             deb_active;
    logic [TimeW-1:0] pending_since;
    logic             rise_flag;
    logic             fall_flag;
    logic             sticky_latch;
  } deb_state_t;

endpackage

/* rtl/core/asymmetric_debounce_edge_latch_unit.sv */
// Debouncer with direction-dependent windows, sticky edge flags and a latch.
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the single output register is refilled in
// the cycle it is taken, so input stalls only while a result waits unread.
// Reset (rst, synchronous, active high) loads the register defaults and the
// matching initial debounce state; any valid register write re-initializes it.
module asymmetric_debounce_edge_latch_unit
  import adel_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WinW-1:0]    cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               sample_valid,
  input  logic               pin_level,
  input  logic [TimeW-1:0]   now_ms,
  input  logic               take_rose,
  input  logic               take_fell,
  input  logic               clear_latch,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               active,
  output logic               latched,
  output logic               rose,
  output logic               fell
);

  logic            polarity;
  logic            initial_level;
  logic            latch_enable;
  logic            immediate_activate;
  logic [WinW-1:0] symmetric_window;
  logic [WinW-1:0] activate_window;
  logic [WinW-1:0] release_window;

  deb_state_t st;
  deb_state_t st_next;
  deb_state_t st_init;
  deb_state_t st_cfg_init;

  logic             in_acc;
  logic             to_active;
  logic [WinW-1:0]  threshold;
  logic [TimeW-1:0] since_eff;
  logic [TimeW-1:0] elapsed;
  logic             do_commit;
  logic             active_next;
  logic             latched_next;
  logic             rose_next;
  logic             fell_next;
  logic             cfg_hit;
  logic             init_level_new;
  logic             polarity_new;

  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Initial state from a given register pair
  function automatic deb_state_t init_state(logic init_lvl, logic act_lvl);
    deb_state_t s;
    s.stable_level    = init_lvl;
    s.candidate_level = init_lvl;
    s.deb_active      = (init_lvl == act_lvl);
    s.pending_since   = '0;
    s.rise_flag       = 1'b0;
    s.fall_flag       = 1'b0;
    s.sticky_latch    = 1'b0;
    return s;
  endfunction

  assign st_init = init_state(RST_INITIAL_LEVEL, RST_POLARITY);

  // Register values as they stand after the current write
  assign cfg_hit = cfg_we && (cfg_index <= REG_RELEASE_WINDOW);
  assign init_level_new =
    (cfg_we && cfg_index == REG_INITIAL_LEVEL) ? cfg_data[0] : initial_level;
  assign polarity_new =
    (cfg_we && cfg_index == REG_POLARITY) ? cfg_data[0] : polarity;
  assign st_cfg_init = init_state(init_level_new, polarity_new);

  // Threshold pick for the direction of this sample
  assign to_active = (pin_level == polarity);

  always_comb begin
    if (to_active && immediate_activate) begin
      threshold = '0;
    end else if (activate_window == '0 && release_window == '0) begin
      threshold = symmetric_window;
    end else if (to_active) begin
      threshold = activate_window;
    end else begin
      threshold = release_window;
    end
  end

  assign since_eff = (pin_level != st.candidate_level) ? now_ms : st.pending_since;
  assign elapsed   = now_ms - since_eff;

  // Sample step, then report, then consume
  always_comb begin
    st_next   = st;
    do_commit = 1'b0;
    if (sample_valid) begin
      if (pin_level == st.stable_level) begin
        st_next.candidate_level = pin_level;
        st_next.pending_since   = now_ms;
      end else if (threshold == '0) begin
        do_commit = 1'b1;
      end else begin
        st_next.candidate_level = pin_level;
        st_next.pending_since   = since_eff;
        if (elapsed >= {{(TimeW-WinW){1'b0}}, threshold}) begin
          do_commit             = 1'b1;
          st_next.pending_since = now_ms;
        end
      end
    end
    if (do_commit) begin
      st_next.stable_level = pin_level;
      if (to_active != st.deb_active) begin
        st_next.deb_active = to_active;
        if (to_active) begin
          st_next.rise_flag = 1'b1;
          if (latch_enable) begin
            st_next.sticky_latch = 1'b1;
          end
        end else begin
          st_next.fall_flag = 1'b1;
        end
      end
    end
    active_next  = st_next.deb_active;
    latched_next = st_next.sticky_latch;
    rose_next    = st_next.rise_flag;
    fell_next    = st_next.fall_flag;
    if (take_rose) begin
      st_next.rise_flag = 1'b0;
    end
    if (take_fell) begin
      st_next.fall_flag = 1'b0;
    end
    if (clear_latch) begin
      st_next.sticky_latch = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      polarity           <= RST_POLARITY;
      initial_level      <= RST_INITIAL_LEVEL;
      latch_enable       <= RST_LATCH_ENABLE;
      immediate_activate <= RST_IMMEDIATE_ACTIVATE;
      symmetric_window   <= RST_SYMMETRIC_WINDOW;
      activate_window    <= RST_ACTIVATE_WINDOW;
      release_window     <= RST_RELEASE_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLARITY:           polarity           <= cfg_data[0];
        REG_INITIAL_LEVEL:      initial_level      <= cfg_data[0];
        REG_LATCH_ENABLE:       latch_enable       <= cfg_data[0];
        REG_IMMEDIATE_ACTIVATE: immediate_activate <= cfg_data[0];
        REG_SYMMETRIC_WINDOW:   symmetric_window   <= cfg_data;
        REG_ACTIVATE_WINDOW:    activate_window    <= cfg_data;
        REG_RELEASE_WINDOW:     release_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_init;
    end else if (cfg_hit) begin
      st <= st_cfg_init;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      active  <= active_next;
      latched <= latched_next;
      rose    <= rose_next;
      fell    <= fell_next;
    end
  end

endmodule
